// ===== rtl/u16esc_pkg.sv =====
// u16esc_pkg: shared types, character codes and helpers of the escape encoder
// used by every module of the block; depends on nothing

package u16esc_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] BUDGET_RESET = 16'd8192;

	localparam logic [15:0] CU_NUL   = 16'h0000;
	localparam logic [15:0] CU_TAB   = 16'h0009;
	localparam logic [15:0] CU_LF    = 16'h000A;
	localparam logic [15:0] CU_CR    = 16'h000D;
	localparam logic [15:0] CU_SPACE = 16'h0020;
	localparam logic [15:0] CU_TILDE = 16'h007E;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;

	localparam logic [15:0] ESC_CTRL_LEN = 16'd2;
	localparam logic [15:0] ESC_UNI_LEN  = 16'd6;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_PRINT,
		JOB_CTRL,
		JOB_UNI
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [15:0] code;
		logic        report;
		logic [15:0] total;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} front_ctl_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] res;
		if (nib < 4'd10) begin
			res = 8'h30 + {4'd0, nib};
		end else begin
			res = 8'h37 + {4'd0, nib};
		end
		return res;
	endfunction

endpackage

// ===== rtl/u16esc_if.sv =====
// u16esc_in_if / u16esc_out_if: valid-ready channels of the escape encoder
// depends on nothing

interface u16esc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;

	modport source(output valid, code_unit, last_unit, input ready);
	modport sink(input valid, code_unit, last_unit, output ready);
endinterface

interface u16esc_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        end_report;
	logic [15:0] total_length;
	logic        run_last;

	modport source(output valid, out_byte, end_report, total_length, run_last, input ready);
	modport sink(input valid, out_byte, end_report, total_length, run_last, output ready);
endinterface

// ===== rtl/u16esc_front.sv =====
// u16esc_front: accepts code units, keeps the budget and length per string,
// classifies each unit into a job; depends on u16esc_pkg, u16esc_if

module u16esc_front
	import u16esc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	u16esc_in_if.sink         in_ch,
	input  logic              queue_full,
	output front_ctl_t        ctl,
	output job_t              job
);

	logic [15:0] out_budget_q;
	logic [15:0] budget_left_q;
	logic [15:0] bytes_written_q;
	logic        string_done_q;

	logic        accept;
	logic [15:0] cu;
	logic        is_ctrl;
	logic        is_print;
	logic        end_now;
	job_kind_t   kind;
	logic [15:0] used;
	logic [15:0] new_budget;
	logic [15:0] new_bytes;
	logic        report;

	assign in_ch.ready = !queue_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cu          = in_ch.code_unit;

	always_comb begin
		is_ctrl  = (cu == CU_CR) || (cu == CU_LF) || (cu == CU_TAB);
		is_print = (cu >= CU_SPACE) && (cu <= CU_TILDE);
		end_now  = (budget_left_q == 16'd0) || (cu == CU_NUL);
		kind     = JOB_NONE;
		used     = 16'd0;
		if (!end_now) begin
			if (is_ctrl) begin
				if (budget_left_q >= ESC_CTRL_LEN) begin
					kind = JOB_CTRL;
					used = ESC_CTRL_LEN;
				end
			end else if (!is_print) begin
				if (budget_left_q >= ESC_UNI_LEN) begin
					kind = JOB_UNI;
					used = ESC_UNI_LEN;
				end
			end else begin
				kind = JOB_PRINT;
				used = 16'd1;
			end
		end
		new_budget = budget_left_q - used;
		new_bytes  = bytes_written_q + used;
		report     = end_now || in_ch.last_unit || (new_budget == 16'd0);

		job.kind   = kind;
		job.code   = cu;
		job.report = report;
		job.total  = new_bytes;

		ctl.full = queue_full;
		ctl.push = accept && !string_done_q && (report || (kind != JOB_NONE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_budget_q    <= BUDGET_RESET;
			budget_left_q   <= BUDGET_RESET;
			bytes_written_q <= 16'd0;
			string_done_q   <= 1'b0;
		end else if (cfg_we) begin
			out_budget_q    <= cfg_wdata;
			budget_left_q   <= cfg_wdata;
			bytes_written_q <= 16'd0;
			string_done_q   <= 1'b0;
		end else if (accept) begin
			if (string_done_q) begin
				if (in_ch.last_unit) begin
					budget_left_q   <= out_budget_q;
					bytes_written_q <= 16'd0;
					string_done_q   <= 1'b0;
				end
			end else if (report) begin
				budget_left_q   <= out_budget_q;
				bytes_written_q <= 16'd0;
				string_done_q   <= !in_ch.last_unit;
			end else begin
				budget_left_q   <= new_budget;
				bytes_written_q <= new_bytes;
			end
		end
	end

endmodule

// ===== rtl/u16esc_queue.sv =====
// u16esc_queue: short job queue between front and back end
// depends on u16esc_pkg

module u16esc_queue
	import u16esc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  front_ctl_t ctl,
	input  job_t       push_job,
	input  logic       pop,
	output job_t       head_job,
	output logic       empty,
	output logic       full
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty    = (count_q == QCNT_W'(0));
	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (ctl.push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !ctl.push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !ctl.full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == QCNT_W'(0)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ on empty queue");

endmodule

// ===== rtl/u16esc_back.sv =====
// u16esc_back: expands queued jobs into escaped bytes and end reports
// depends on u16esc_pkg, u16esc_if

module u16esc_back
	import u16esc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        job,
	input  logic        job_valid,
	output logic        pop,
	u16esc_out_if.source out_ch
);

	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        end_report_q;
	logic [15:0] total_length_q;
	logic        run_last_q;

	logic [2:0]  nbytes;
	logic [2:0]  nres;
	logic        advance;
	logic        is_last;
	logic        is_byte;
	logic [7:0]  byte_val;
	logic [3:0]  nib;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.end_report   = end_report_q;
	assign out_ch.total_length = total_length_q;
	assign out_ch.run_last     = run_last_q;

	always_comb begin
		case (job.kind)
			JOB_PRINT: nbytes = 3'd1;
			JOB_CTRL:  nbytes = 3'd2;
			JOB_UNI:   nbytes = 3'd6;
			default:   nbytes = 3'd0;
		endcase
		nres    = nbytes + {2'd0, job.report};
		advance = job_valid && (!out_valid_q || out_ch.ready);
		is_last = (step_q == (nres - 3'd1));
		is_byte = (step_q < nbytes);
		pop     = advance && is_last;

		case (step_q)
			3'd2:    nib = job.code[15:12];
			3'd3:    nib = job.code[11:8];
			3'd4:    nib = job.code[7:4];
			default: nib = job.code[3:0];
		endcase

		byte_val = 8'd0;
		case (job.kind)
			JOB_PRINT: byte_val = job.code[7:0];
			JOB_CTRL: begin
				if (step_q == 3'd0) begin
					byte_val = CH_BSLASH;
				end else if (job.code == CU_CR) begin
					byte_val = CH_R;
				end else if (job.code == CU_LF) begin
					byte_val = CH_N;
				end else begin
					byte_val = CH_T;
				end
			end
			JOB_UNI: begin
				if (step_q == 3'd0) begin
					byte_val = CH_BSLASH;
				end else if (step_q == 3'd1) begin
					byte_val = CH_U;
				end else begin
					byte_val = hex_digit(nib);
				end
			end
			default: byte_val = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= 3'd0;
			out_valid_q    <= 1'b0;
			out_byte_q     <= 8'd0;
			end_report_q   <= 1'b0;
			total_length_q <= 16'd0;
			run_last_q     <= 1'b0;
		end else if (advance) begin
			step_q         <= is_last ? 3'd0 : step_q + 3'd1;
			out_valid_q    <= 1'b1;
			out_byte_q     <= is_byte ? byte_val : 8'd0;
			end_report_q   <= !is_byte;
			total_length_q <= is_byte ? 16'd0 : job.total;
			run_last_q     <= is_last;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (step_q < nres)) else $error("step beyond job length");
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!job_valid |-> (step_q == 3'd0)) else $error("step left over without job");
	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_report_q) |-> run_last_q)
		else $error("report not last result of item");

endmodule

// ===== rtl/utf16_escape_encoder_unit.sv =====
// utf16_escape_encoder_unit: UCS-2 to backslash-u escaped ASCII encoder
// depends on u16esc_pkg, u16esc_if, u16esc_front, u16esc_queue, u16esc_back
//
// in_ch carries code_unit and last_unit; out_ch carries one result per
// transfer: an escaped byte, or an end report with the string's length.
// run_last marks the final result caused by one input unit. cfg_we with
// cfg_wdata loads the byte budget per string and restarts the string.
// The front end takes one unit per cycle whenever the four-entry job queue
// has room, updating budget and length at once. The back end turns one
// job into 1 to 7 results, one per cycle while the receiver takes them,
// through a registered output. A unit's job is written into the queue, and
// its first result then passes through the output register. Sustained rate
// is one result per cycle while the receiver is ready (up to six bytes plus
// a report per unit); units yielding no result never reach the queue.
// Reset loads a budget of 8192 bytes and empties the queue. When the
// receiver stalls, the output register holds, the back end waits, and the
// front end keeps accepting until the queue is full.

module utf16_escape_encoder_unit
	import u16esc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	u16esc_in_if.sink    in_ch,
	u16esc_out_if.source out_ch
);

	front_ctl_t ctl;
	job_t       push_job;
	job_t       head_job;
	logic       q_empty;
	logic       q_full;
	logic       pop;

	u16esc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.queue_full (q_full),
		.ctl        (ctl),
		.job        (push_job)
	);

	u16esc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	u16esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (!q_empty),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
